### src/lacb_pkg.sv
// Types, constants and step functions for the look-at camera basis pipeline.
// No dependencies; used by look_at_camera_basis.
package lacb_pkg;

    localparam int DIFF_W     = 33;                   // eye - target
    localparam int MAG_W      = 30;                   // magnitude after range shift
    localparam int SQ_W       = 62;                   // sum of squares
    localparam int ROOT_STEPS = 31;                   // one root bit per stage
    localparam int ROOT_W     = 31;
    localparam int FRAC_W     = 14;                   // Q1.14 fraction bits
    localparam int QUO_W      = 15;                   // quotient bits, value <= 16384
    localparam int REM_W      = 32;
    localparam int NUM_W      = MAG_W + FRAC_W + 1;   // |a| * 2^14 + r/2
    localparam int UNITS      = 5;                    // three forward, two right dividers
    localparam int AXIS_W     = 16;
    localparam int PROD_W     = 32;

    localparam logic [QUO_W-1:0] Q14_ONE = QUO_W'(16384);
    localparam logic [FRAC_W:0]  Q14_HALF = (FRAC_W+1)'(8192);

    typedef struct packed {
        logic                    deg;
        logic [2:0]              sgn_f;
        logic [1:0]              sgn_r;   // [0]: sign of dz, [1]: sign of -dx
        logic [2:0][MAG_W-1:0]   af;
        logic [1:0][MAG_W-1:0]   ar;      // [0]: |dz|, [1]: |dx|
    } side_t;

    typedef struct packed {
        logic [SQ_W:0] rem;
        logic [SQ_W:0] res;
    } root_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] nlow;
        logic [QUO_W-1:0] quo;
    } div_t;

    // One step of the digit-by-digit square root.
    function automatic root_t root_step(root_t cur, logic [SQ_W:0] bval);
        root_t         nxt;
        logic [SQ_W:0] trial;
        trial = cur.res + bval;
        if (cur.rem >= trial) begin
            nxt.rem = cur.rem - trial;
            nxt.res = (cur.res >> 1) + bval;
        end else begin
            nxt.rem = cur.rem;
            nxt.res = cur.res >> 1;
        end
        return nxt;
    endfunction

    // Numerator |a| * 2^14 + floor(r/2); top bits preload the remainder.
    function automatic div_t div_init(logic [MAG_W-1:0] mag, logic [ROOT_W-1:0] den);
        div_t             d;
        logic [NUM_W-1:0] num;
        num    = NUM_W'({mag, {FRAC_W{1'b0}}}) + NUM_W'(den >> 1);
        d.rem  = REM_W'(num[NUM_W-1:QUO_W]);
        d.nlow = num[QUO_W-1:0];
        d.quo  = '0;
        return d;
    endfunction

    // One restoring division step.
    function automatic div_t div_step(div_t cur, logic [ROOT_W-1:0] den);
        div_t             nxt;
        logic [REM_W-1:0] trial;
        logic             qb;
        trial = {cur.rem[REM_W-2:0], cur.nlow[QUO_W-1]};
        qb    = (trial >= REM_W'(den));
        nxt.rem  = qb ? trial - REM_W'(den) : trial;
        nxt.nlow = {cur.nlow[QUO_W-2:0], 1'b0};
        nxt.quo  = {cur.quo[QUO_W-2:0], qb};
        return nxt;
    endfunction

    function automatic logic signed [AXIS_W-1:0] to_q14(logic [QUO_W-1:0] q, logic neg);
        logic [AXIS_W-1:0] qs;
        qs = (q > Q14_ONE) ? AXIS_W'(Q14_ONE) : AXIS_W'(q);
        return neg ? -$signed(qs) : $signed(qs);
    endfunction

    // Divide a Q2.28 value by 2^14, half away from zero, saturate to +-1.0.
    function automatic logic signed [AXIS_W-1:0] round_q14(logic signed [PROD_W:0] v);
        logic [PROD_W:0]   mag;
        logic [PROD_W:0]   q;
        logic [AXIS_W-1:0] qs;
        mag = v[PROD_W] ? $unsigned(-v) : $unsigned(v);
        q   = (mag + (PROD_W+1)'(Q14_HALF)) >> FRAC_W;
        qs  = (q > (PROD_W+1)'(Q14_ONE)) ? AXIS_W'(Q14_ONE) : AXIS_W'(q);
        return v[PROD_W] ? -$signed(qs) : $signed(qs);
    endfunction

endpackage

### src/look_at_camera_basis.sv
// Look-at camera basis: streaming pipeline from eye/target points to right/up/forward axes.
// Depends on lacb_pkg (types, constants, root and divide step functions).

// One beat in gives one beat out. The block takes a new beat on every cycle
// while the result side is not stalled. Its stages are difference,
// magnitude, range shift, squaring and summing; 31 square-root stages, one
// root bit each; one divide setup stage and 15 restoring divide stages, one
// quotient bit each; one stage for sign and saturation; two for the up-axis
// products and rounding. Throughput is one beat per cycle when not stalled. The
// whole pipeline advances together; a beat held on the output (m_valid high,
// m_ready low) freezes every stage and drops s_ready. Forward is
// normalize(eye - target), right is normalize of (dz, -dx) with right_y zero,
// up is forward x right. All axes are signed Q1.14. When dx and dz are both
// zero the degenerate flag is set and all axes are zero.
module look_at_camera_basis (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_eye_x,
    input  logic signed [31:0]  s_eye_y,
    input  logic signed [31:0]  s_eye_z,
    input  logic signed [31:0]  s_target_x,
    input  logic signed [31:0]  s_target_y,
    input  logic signed [31:0]  s_target_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_right_x,
    output logic signed [15:0]  m_right_y,
    output logic signed [15:0]  m_right_z,
    output logic signed [15:0]  m_up_x,
    output logic signed [15:0]  m_up_y,
    output logic signed [15:0]  m_up_z,
    output logic signed [15:0]  m_fwd_x,
    output logic signed [15:0]  m_fwd_y,
    output logic signed [15:0]  m_fwd_z,
    output logic                m_degenerate
);
    import lacb_pkg::*;

    // Global advance: every stage moves when the output slot is free or taken.
    logic adv;

    // Stage A: differences
    logic                     va_reg;
    logic signed [DIFF_W-1:0] da_reg [3];

    // Stage B: magnitudes and signs
    logic                     vb_reg;
    logic                     degb_reg;
    logic [DIFF_W-1:0]        mb_reg [3];
    logic [2:0]               sgnb_reg;

    // Stage C: range-shifted magnitudes
    logic                     vc_reg;
    side_t                    sc_reg;
    side_t                    sc_next;
    logic [DIFF_W-1:0]        orf;
    logic [DIFF_W-1:0]        orr;
    logic [1:0]               sf;
    logic [1:0]               sr;

    // Stage D: squares
    logic                     vd_reg;
    side_t                    sd_reg;
    logic [2*MAG_W-1:0]       sqf_reg [3];
    logic [2*MAG_W-1:0]       sqr_reg [2];

    // Square-root pipeline, index 0 is the sum-of-squares stage
    logic                     vr_reg   [0:ROOT_STEPS];
    side_t                    sr_reg   [0:ROOT_STEPS];
    root_t                    rootf_reg[0:ROOT_STEPS];
    root_t                    rootr_reg[0:ROOT_STEPS];

    // Divide pipeline, index 0 is the setup stage
    logic                     vq_reg   [0:QUO_W];
    logic                     degq_reg [0:QUO_W];
    logic [4:0]               sgnq_reg [0:QUO_W];
    logic [ROOT_W-1:0]        denf_reg [0:QUO_W];
    logic [ROOT_W-1:0]        denr_reg [0:QUO_W];
    div_t                     dv_reg   [0:QUO_W][UNITS];
    logic [ROOT_W-1:0]        denf_next;
    logic [ROOT_W-1:0]        denr_next;

    // Stage G: signed Q1.14 forward and right
    logic                     vg_reg;
    logic                     degg_reg;
    logic signed [AXIS_W-1:0] fg_reg [3];
    logic signed [AXIS_W-1:0] rg_reg [2];

    // Stage U: up-axis products
    logic                     vu_reg;
    logic                     degu_reg;
    logic signed [AXIS_W-1:0] fu_reg [3];
    logic signed [AXIS_W-1:0] ru_reg [2];
    logic signed [PROD_W-1:0] pu_reg [4];

    // Output register
    logic                     m_valid_reg;
    logic                     m_deg_reg;
    logic signed [AXIS_W-1:0] m_rx_reg;
    logic signed [AXIS_W-1:0] m_rz_reg;
    logic signed [AXIS_W-1:0] m_u_reg [3];
    logic signed [AXIS_W-1:0] m_f_reg [3];

    logic [AXIS_W-1:0]        rx_abs;
    logic [AXIS_W-1:0]        rz_abs;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- Stage A ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            da_reg[0] <= $signed({s_eye_x[31], s_eye_x}) - $signed({s_target_x[31], s_target_x});
            da_reg[1] <= $signed({s_eye_y[31], s_eye_y}) - $signed({s_target_y[31], s_target_y});
            da_reg[2] <= $signed({s_eye_z[31], s_eye_z}) - $signed({s_target_z[31], s_target_z});
        end
    end

    // ---------------- Stage B ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                mb_reg[i]   <= da_reg[i][DIFF_W-1] ? $unsigned(-da_reg[i]) : $unsigned(da_reg[i]);
                sgnb_reg[i] <= da_reg[i][DIFF_W-1];
            end
            degb_reg <= (da_reg[0] == '0) && (da_reg[2] == '0);
        end
    end

    // ---------------- Stage C ----------------
    // Smallest shift that brings the largest magnitude below 2^30.
    always_comb begin
        orf = mb_reg[0] | mb_reg[1] | mb_reg[2];
        orr = mb_reg[0] | mb_reg[2];
        sf  = orf[32] ? 2'd3 : (orf[31] ? 2'd2 : (orf[30] ? 2'd1 : 2'd0));
        sr  = orr[32] ? 2'd3 : (orr[31] ? 2'd2 : (orr[30] ? 2'd1 : 2'd0));
        sc_next.deg   = degb_reg;
        sc_next.sgn_f = sgnb_reg;
        sc_next.sgn_r = {~sgnb_reg[0], sgnb_reg[2]};
        for (int i = 0; i < 3; i++) begin
            sc_next.af[i] = MAG_W'(mb_reg[i] >> sf);
        end
        sc_next.ar[0] = MAG_W'(mb_reg[2] >> sr);
        sc_next.ar[1] = MAG_W'(mb_reg[0] >> sr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (adv) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sc_reg <= sc_next;
        end
    end

    // ---------------- Stage D ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (adv) begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg <= sc_reg;
            for (int i = 0; i < 3; i++) begin
                sqf_reg[i] <= (2*MAG_W)'(sc_reg.af[i]) * (2*MAG_W)'(sc_reg.af[i]);
            end
            for (int i = 0; i < 2; i++) begin
                sqr_reg[i] <= (2*MAG_W)'(sc_reg.ar[i]) * (2*MAG_W)'(sc_reg.ar[i]);
            end
        end
    end

    // ---------------- Sum of squares (root stage 0) ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg[0] <= 1'b0;
        end else if (adv) begin
            vr_reg[0] <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sr_reg[0]        <= sd_reg;
            rootf_reg[0].rem <= (SQ_W+1)'(sqf_reg[0]) + (SQ_W+1)'(sqf_reg[1])
                              + (SQ_W+1)'(sqf_reg[2]);
            rootf_reg[0].res <= '0;
            rootr_reg[0].rem <= (SQ_W+1)'(sqr_reg[0]) + (SQ_W+1)'(sqr_reg[1]);
            rootr_reg[0].res <= '0;
        end
    end

    // ---------------- Square root, one bit per stage ----------------
    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        localparam logic [SQ_W:0] BVAL = (SQ_W+1)'(1) << (2 * (ROOT_STEPS - 1 - j));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vr_reg[j+1] <= 1'b0;
            end else if (adv) begin
                vr_reg[j+1] <= vr_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sr_reg[j+1]    <= sr_reg[j];
                rootf_reg[j+1] <= root_step(rootf_reg[j], BVAL);
                rootr_reg[j+1] <= root_step(rootr_reg[j], BVAL);
            end
        end
    end

    // ---------------- Divide setup ----------------
    always_comb begin
        denf_next = rootf_reg[ROOT_STEPS].res[ROOT_W-1:0];
        denr_next = rootr_reg[ROOT_STEPS].res[ROOT_W-1:0];
        if (denf_next == '0) begin
            denf_next = ROOT_W'(1);
        end
        if (denr_next == '0) begin
            denr_next = ROOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg[0] <= 1'b0;
        end else if (adv) begin
            vq_reg[0] <= vr_reg[ROOT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degq_reg[0] <= sr_reg[ROOT_STEPS].deg;
            sgnq_reg[0] <= {sr_reg[ROOT_STEPS].sgn_r, sr_reg[ROOT_STEPS].sgn_f};
            denf_reg[0] <= denf_next;
            denr_reg[0] <= denr_next;
            for (int i = 0; i < 3; i++) begin
                dv_reg[0][i] <= div_init(sr_reg[ROOT_STEPS].af[i], denf_next);
            end
            for (int i = 0; i < 2; i++) begin
                dv_reg[0][3+i] <= div_init(sr_reg[ROOT_STEPS].ar[i], denr_next);
            end
        end
    end

    // ---------------- Restoring divide, one quotient bit per stage ----------------
    for (genvar t = 0; t < QUO_W; t++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vq_reg[t+1] <= 1'b0;
            end else if (adv) begin
                vq_reg[t+1] <= vq_reg[t];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                degq_reg[t+1] <= degq_reg[t];
                sgnq_reg[t+1] <= sgnq_reg[t];
                denf_reg[t+1] <= denf_reg[t];
                denr_reg[t+1] <= denr_reg[t];
                for (int i = 0; i < 3; i++) begin
                    dv_reg[t+1][i] <= div_step(dv_reg[t][i], denf_reg[t]);
                end
                for (int i = 3; i < UNITS; i++) begin
                    dv_reg[t+1][i] <= div_step(dv_reg[t][i], denr_reg[t]);
                end
            end
        end
    end

    // ---------------- Stage G: sign and saturation ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (adv) begin
            vg_reg <= vq_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degg_reg <= degq_reg[QUO_W];
            for (int i = 0; i < 3; i++) begin
                fg_reg[i] <= to_q14(dv_reg[QUO_W][i].quo, sgnq_reg[QUO_W][i]);
            end
            for (int i = 0; i < 2; i++) begin
                rg_reg[i] <= to_q14(dv_reg[QUO_W][3+i].quo, sgnq_reg[QUO_W][3+i]);
            end
        end
    end

    // ---------------- Stage U: up-axis products ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vu_reg <= 1'b0;
        end else if (adv) begin
            vu_reg <= vg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degu_reg  <= degg_reg;
            fu_reg    <= fg_reg;
            ru_reg    <= rg_reg;
            pu_reg[0] <= PROD_W'(fg_reg[1]) * PROD_W'(rg_reg[1]);   // fy * rz
            pu_reg[1] <= PROD_W'(fg_reg[2]) * PROD_W'(rg_reg[0]);   // fz * rx
            pu_reg[2] <= PROD_W'(fg_reg[0]) * PROD_W'(rg_reg[1]);   // fx * rz
            pu_reg[3] <= PROD_W'(fg_reg[1]) * PROD_W'(rg_reg[0]);   // fy * rx
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vu_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_deg_reg <= degu_reg;
            if (degu_reg) begin
                m_rx_reg <= '0;
                m_rz_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    m_u_reg[i] <= '0;
                    m_f_reg[i] <= '0;
                end
            end else begin
                m_rx_reg   <= ru_reg[0];
                m_rz_reg   <= ru_reg[1];
                m_f_reg    <= fu_reg;
                m_u_reg[0] <= round_q14((PROD_W+1)'(pu_reg[0]));
                m_u_reg[1] <= round_q14((PROD_W+1)'(pu_reg[1]) - (PROD_W+1)'(pu_reg[2]));
                m_u_reg[2] <= round_q14(-((PROD_W+1)'(pu_reg[3])));
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_degenerate = m_deg_reg;
    assign m_right_x    = m_rx_reg;
    assign m_right_y    = '0;
    assign m_right_z    = m_rz_reg;
    assign m_up_x       = m_u_reg[0];
    assign m_up_y       = m_u_reg[1];
    assign m_up_z       = m_u_reg[2];
    assign m_fwd_x      = m_f_reg[0];
    assign m_fwd_y      = m_f_reg[1];
    assign m_fwd_z      = m_f_reg[2];

    // ---------------- Assertions ----------------
    always_comb begin
        rx_abs = m_rx_reg[AXIS_W-1] ? $unsigned(-m_rx_reg) : $unsigned(m_rx_reg);
        rz_abs = m_rz_reg[AXIS_W-1] ? $unsigned(-m_rz_reg) : $unsigned(m_rz_reg);
    end

    a_reset_clears_output: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_right_x == '0 && m_right_z == '0 &&
        m_up_x == '0 && m_up_y == '0 && m_up_z == '0 &&
        m_fwd_x == '0 && m_fwd_y == '0 && m_fwd_z == '0))
        else $error("degenerate beat with nonzero axes");

    // A normalized 2D vector has one component of at least 1/sqrt(2).
    a_right_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_degenerate) |-> (rx_abs >= 16'd11000 || rz_abs >= 16'd11000))
        else $error("right axis not normalized");

endmodule
